// ===== design/rsnp_pkg.sv =====
package rsnp_pkg;

  localparam int unsigned OBJ_MAX     = 64;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned CRD_W       = 32;
  localparam int unsigned DIR_W       = 18;
  localparam int unsigned RAD_W       = 32;
  localparam int unsigned OC_W        = CRD_W + 1;
  localparam int unsigned CHUNK_W     = 18;
  localparam int unsigned OPA_W       = 53;
  localparam int unsigned PROD_W      = OPA_W + CHUNK_W;
  localparam int unsigned BB_W        = 54;
  localparam int unsigned ACC_W       = 108;
  localparam int unsigned SUM_W       = 68;
  localparam int unsigned RR_W        = RAD_W + FRAC_BITS;
  localparam int unsigned DIFF_W      = SUM_W + 1;
  localparam int unsigned DISC_W      = ACC_W + 2;
  localparam int unsigned ROOT_W      = ACC_W / 2;
  localparam int unsigned REM_W       = ROOT_W + 2;
  localparam int unsigned T_W         = 56;
  localparam int unsigned DIST_W      = 31;
  localparam int unsigned SQRT_STEPS  = ROOT_W;
  localparam int unsigned SQC_W       = 6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PICK = 1'b1;

  localparam logic REG_OBJ_COUNT = 1'b0;
  localparam logic REG_RADIUS    = 1'b1;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_READ = 12'b0000_0000_0010,
    S_OC   = 12'b0000_0000_0100,
    S_MAG  = 12'b0000_0000_1000,
    S_MAC  = 12'b0000_0001_0000,
    S_DIFF = 12'b0000_0010_0000,
    S_DISC = 12'b0000_0100_0000,
    S_SQRT = 12'b0000_1000_0000,
    S_TVAL = 12'b0001_0000_0000,
    S_CMP  = 12'b0010_0000_0000,
    S_NEXT = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_e;

  // MAC micro-steps: dot product, three squares, then b squared
  typedef enum logic [3:0] {
    MAC_DX, MAC_DY, MAC_DZ,
    MAC_XX0, MAC_XX1, MAC_YY0, MAC_YY1, MAC_ZZ0, MAC_ZZ1,
    MAC_BB0, MAC_BB1, MAC_BB2
  } mac_step_e;

  typedef struct packed {
    logic              load_we;
    logic              load_res;
    logic              pick_init;
    logic              mem_rd;
    logic              oc_en;
    logic              mag_en;
    logic              mac_en;
    mac_step_e         mac_step;
    logic              diff_en;
    logic              disc_en;
    logic              sqrt_step;
    logic              t_en;
    logic              cmp_en;
    logic              fin_en;
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic disc_neg;
  } status_t;

endpackage

// ===== design/rsnp_sqrt.sv =====
module rsnp_sqrt (
  input  logic                           clk_i,
  input  logic                           init_i,
  input  logic                           step_i,
  input  logic [rsnp_pkg::ACC_W-1:0]     value_i,
  output logic [rsnp_pkg::ROOT_W-1:0]    root_o
);

  logic [rsnp_pkg::ACC_W-1:0]  rad_q;
  logic [rsnp_pkg::REM_W-1:0]  rem_q;
  logic [rsnp_pkg::ROOT_W-1:0] root_q;
  logic [rsnp_pkg::REM_W+1:0]  rem_n;
  logic [rsnp_pkg::REM_W+1:0]  trial;
  logic                        take;

  // one result bit per step, two radicand bits brought down
  assign rem_n = {rem_q, rad_q[rsnp_pkg::ACC_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign take  = (rem_n >= trial);

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      rad_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      rad_q  <= {rad_q[rsnp_pkg::ACC_W-3:0], 2'b00};
      rem_q  <= take ? rsnp_pkg::REM_W'(rem_n - trial) : rsnp_pkg::REM_W'(rem_n);
      root_q <= {root_q[rsnp_pkg::ROOT_W-2:0], take};
    end
  end

  assign root_o = root_q;

endmodule

// ===== design/rsnp_ctrl.sv =====
module rsnp_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         opcode_i,
  input  logic [rsnp_pkg::CNT_W-1:0]   obj_count_i,
  input  rsnp_pkg::status_t            status_i,
  output rsnp_pkg::cmd_t               cmd_o,
  output logic                         busy_o
);

  rsnp_pkg::state_e             state_q, state_d;
  rsnp_pkg::mac_step_e          step_q, step_d;
  logic [rsnp_pkg::SLOT_W-1:0]  idx_q, idx_d;
  logic [rsnp_pkg::SQC_W-1:0]   sqc_q, sqc_d;
  logic [rsnp_pkg::CNT_W-1:0]   n_cnt;
  logic                         last;

  assign n_cnt = (obj_count_i > rsnp_pkg::CNT_W'(rsnp_pkg::OBJ_MAX)) ?
                 rsnp_pkg::CNT_W'(rsnp_pkg::OBJ_MAX) : obj_count_i;
  assign last  = ({1'b0, idx_q} == rsnp_pkg::CNT_W'(n_cnt - 1'b1));

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    idx_d        = idx_q;
    sqc_d        = sqc_q;
    cmd_o        = '0;
    cmd_o.idx    = idx_q;
    cmd_o.mac_step = step_q;
    case (state_q)
      rsnp_pkg::S_IDLE: begin
        if (start_i) begin
          if (opcode_i == rsnp_pkg::OP_LOAD) begin
            cmd_o.load_we  = 1'b1;
            cmd_o.load_res = 1'b1;
          end else begin
            cmd_o.pick_init = 1'b1;
            idx_d   = '0;
            state_d = (n_cnt == '0) ? rsnp_pkg::S_FIN : rsnp_pkg::S_READ;
          end
        end
      end
      rsnp_pkg::S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d = rsnp_pkg::S_OC;
      end
      rsnp_pkg::S_OC: begin
        cmd_o.oc_en = 1'b1;
        state_d = rsnp_pkg::S_MAG;
      end
      rsnp_pkg::S_MAG: begin
        cmd_o.mag_en = 1'b1;
        step_d  = rsnp_pkg::MAC_DX;
        state_d = rsnp_pkg::S_MAC;
      end
      rsnp_pkg::S_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (step_q == rsnp_pkg::MAC_BB2) begin
          state_d = rsnp_pkg::S_DIFF;
        end else begin
          step_d = rsnp_pkg::mac_step_e'(step_q + 1'b1);
        end
      end
      rsnp_pkg::S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d = rsnp_pkg::S_DISC;
      end
      rsnp_pkg::S_DISC: begin
        cmd_o.disc_en = 1'b1;
        sqc_d   = '0;
        state_d = rsnp_pkg::S_SQRT;
      end
      rsnp_pkg::S_SQRT: begin
        if (status_i.disc_neg) begin
          state_d = rsnp_pkg::S_NEXT;
        end else begin
          cmd_o.sqrt_step = 1'b1;
          if (sqc_q == rsnp_pkg::SQC_W'(rsnp_pkg::SQRT_STEPS - 1)) begin
            state_d = rsnp_pkg::S_TVAL;
          end else begin
            sqc_d = sqc_q + 1'b1;
          end
        end
      end
      rsnp_pkg::S_TVAL: begin
        cmd_o.t_en = 1'b1;
        state_d = rsnp_pkg::S_CMP;
      end
      rsnp_pkg::S_CMP: begin
        cmd_o.cmp_en = 1'b1;
        state_d = rsnp_pkg::S_NEXT;
      end
      rsnp_pkg::S_NEXT: begin
        if (last) begin
          state_d = rsnp_pkg::S_FIN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = rsnp_pkg::S_READ;
        end
      end
      rsnp_pkg::S_FIN: begin
        cmd_o.fin_en = 1'b1;
        state_d = rsnp_pkg::S_IDLE;
      end
      default: begin
        state_d = rsnp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsnp_pkg::S_IDLE;
      step_q  <= rsnp_pkg::MAC_DX;
      idx_q   <= '0;
      sqc_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      sqc_q   <= sqc_d;
    end
  end

  assign busy_o = (state_q != rsnp_pkg::S_IDLE);

endmodule

// ===== design/rsnp_dp.sv =====
module rsnp_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rsnp_pkg::cmd_t                      cmd_i,
  output rsnp_pkg::status_t                   status_o,
  input  logic [rsnp_pkg::RAD_W-1:0]          radius_sq_i,
  input  logic [rsnp_pkg::SLOT_W-1:0]         slot_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   center_x_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   center_y_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   center_z_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   origin_x_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   origin_y_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   origin_z_i,
  input  logic signed [rsnp_pkg::DIR_W-1:0]   dir_x_i,
  input  logic signed [rsnp_pkg::DIR_W-1:0]   dir_y_i,
  input  logic signed [rsnp_pkg::DIR_W-1:0]   dir_z_i,
  output logic                                res_vld_o,
  output logic                                hit_found_o,
  output logic [rsnp_pkg::SLOT_W-1:0]         hit_slot_o,
  output logic [rsnp_pkg::DIST_W-1:0]         hit_dist_o,
  output logic                                sel_chg_o
);

  localparam int unsigned ENT_W = 3 * rsnp_pkg::CRD_W;

  logic [ENT_W-1:0] mem_q [rsnp_pkg::OBJ_MAX];
  logic [ENT_W-1:0] rd_q;

  logic signed [rsnp_pkg::CRD_W-1:0]  org_q [3];
  logic [rsnp_pkg::DIR_W-1:0]         dmag_q [3];
  logic [2:0]                         dsgn_q;
  logic signed [rsnp_pkg::OC_W-1:0]   oc_q [3];
  logic [rsnp_pkg::OC_W-1:0]          omag_q [3];
  logic [2:0]                         osgn_q;
  logic signed [rsnp_pkg::CRD_W-1:0]  cen [3];

  logic [rsnp_pkg::OPA_W-1:0]   op_a;
  logic [rsnp_pkg::CHUNK_W-1:0] op_b;
  logic [1:0]                   op_sh;
  logic                         op_clr, op_sub;

  logic [rsnp_pkg::PROD_W-1:0]  prod_q;
  logic                         p_vld_q;
  logic [1:0]                   p_sh_q;
  logic                         p_clr_q, p_sub_q;
  rsnp_pkg::mac_step_e          p_step_q;
  logic [rsnp_pkg::ACC_W-1:0]   acc_q, acc_base, acc_sh;
  logic [rsnp_pkg::BB_W-1:0]    bb_abs;

  logic signed [rsnp_pkg::BB_W-1:0]   bb_q;
  logic [rsnp_pkg::OPA_W-1:0]         bb_mag_q;
  logic [rsnp_pkg::SUM_W-1:0]         sum_q;
  logic signed [rsnp_pkg::DIFF_W-1:0] diff_q;
  logic signed [rsnp_pkg::DISC_W-1:0] disc_full;
  logic                               disc_neg_q;
  logic [rsnp_pkg::ROOT_W-1:0]        root;
  logic signed [rsnp_pkg::T_W-1:0]    t_q;

  logic                               found_q;
  logic signed [rsnp_pkg::T_W-1:0]    best_t_q;
  logic [rsnp_pkg::SLOT_W-1:0]        best_slot_q;
  logic                               sel_vld_q;
  logic [rsnp_pkg::SLOT_W-1:0]        sel_slot_q;
  logic [rsnp_pkg::T_W-rsnp_pkg::FRAC_BITS-1:0] dist_full;

  // centre table, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mem_q[slot_i] <= {center_z_i, center_y_i, center_x_i};
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[cmd_i.idx];
    end
  end

  assign cen[0] = rd_q[rsnp_pkg::CRD_W-1:0];
  assign cen[1] = rd_q[2*rsnp_pkg::CRD_W-1:rsnp_pkg::CRD_W];
  assign cen[2] = rd_q[3*rsnp_pkg::CRD_W-1:2*rsnp_pkg::CRD_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick_init) begin
      org_q[0]  <= origin_x_i;
      org_q[1]  <= origin_y_i;
      org_q[2]  <= origin_z_i;
      dsgn_q    <= {dir_z_i[rsnp_pkg::DIR_W-1], dir_y_i[rsnp_pkg::DIR_W-1],
                    dir_x_i[rsnp_pkg::DIR_W-1]};
      dmag_q[0] <= dir_x_i[rsnp_pkg::DIR_W-1] ? rsnp_pkg::DIR_W'(-dir_x_i) : dir_x_i;
      dmag_q[1] <= dir_y_i[rsnp_pkg::DIR_W-1] ? rsnp_pkg::DIR_W'(-dir_y_i) : dir_y_i;
      dmag_q[2] <= dir_z_i[rsnp_pkg::DIR_W-1] ? rsnp_pkg::DIR_W'(-dir_z_i) : dir_z_i;
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.oc_en) begin
        oc_q[k] <= rsnp_pkg::OC_W'(org_q[k]) - rsnp_pkg::OC_W'(cen[k]);
      end
      if (cmd_i.mag_en) begin
        osgn_q[k] <= oc_q[k][rsnp_pkg::OC_W-1];
        omag_q[k] <= oc_q[k][rsnp_pkg::OC_W-1] ? rsnp_pkg::OC_W'(-oc_q[k]) : oc_q[k];
      end
    end
  end

  // operand selection for each MAC step
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sh  = 2'd0;
    op_clr = 1'b0;
    op_sub = 1'b0;
    case (cmd_i.mac_step)
      rsnp_pkg::MAC_DX: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[0]); op_b = dmag_q[0];
        op_clr = 1'b1; op_sub = osgn_q[0] ^ dsgn_q[0];
      end
      rsnp_pkg::MAC_DY: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[1]); op_b = dmag_q[1];
        op_sub = osgn_q[1] ^ dsgn_q[1];
      end
      rsnp_pkg::MAC_DZ: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[2]); op_b = dmag_q[2];
        op_sub = osgn_q[2] ^ dsgn_q[2];
      end
      rsnp_pkg::MAC_XX0: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[0]); op_b = omag_q[0][17:0]; op_clr = 1'b1;
      end
      rsnp_pkg::MAC_XX1: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[0]);
        op_b = rsnp_pkg::CHUNK_W'(omag_q[0][rsnp_pkg::OC_W-1:18]); op_sh = 2'd1;
      end
      rsnp_pkg::MAC_YY0: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[1]); op_b = omag_q[1][17:0];
      end
      rsnp_pkg::MAC_YY1: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[1]);
        op_b = rsnp_pkg::CHUNK_W'(omag_q[1][rsnp_pkg::OC_W-1:18]); op_sh = 2'd1;
      end
      rsnp_pkg::MAC_ZZ0: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[2]); op_b = omag_q[2][17:0];
      end
      rsnp_pkg::MAC_ZZ1: begin
        op_a = rsnp_pkg::OPA_W'(omag_q[2]);
        op_b = rsnp_pkg::CHUNK_W'(omag_q[2][rsnp_pkg::OC_W-1:18]); op_sh = 2'd1;
      end
      rsnp_pkg::MAC_BB0: begin
        op_a = bb_mag_q; op_b = bb_mag_q[17:0]; op_clr = 1'b1;
      end
      rsnp_pkg::MAC_BB1: begin
        op_a = bb_mag_q; op_b = bb_mag_q[35:18]; op_sh = 2'd1;
      end
      rsnp_pkg::MAC_BB2: begin
        op_a = bb_mag_q; op_b = rsnp_pkg::CHUNK_W'(bb_mag_q[rsnp_pkg::OPA_W-1:36]);
        op_sh = 2'd2;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // stage 1: product; stage 2: shift and accumulate
  always_ff @(posedge clk_i) begin
    prod_q   <= rsnp_pkg::PROD_W'(op_a) * rsnp_pkg::PROD_W'(op_b);
    p_sh_q   <= op_sh;
    p_clr_q  <= op_clr;
    p_sub_q  <= op_sub;
    p_step_q <= cmd_i.mac_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.mac_en;
    end
  end

  always_comb begin
    case (p_sh_q)
      2'd1:    acc_sh = rsnp_pkg::ACC_W'(prod_q) << rsnp_pkg::CHUNK_W;
      2'd2:    acc_sh = rsnp_pkg::ACC_W'(prod_q) << (2 * rsnp_pkg::CHUNK_W);
      default: acc_sh = rsnp_pkg::ACC_W'(prod_q);
    endcase
    acc_base = p_clr_q ? '0 : acc_q;
    bb_abs   = acc_q[rsnp_pkg::BB_W-1] ? rsnp_pkg::BB_W'(-acc_q[rsnp_pkg::BB_W-1:0]) :
                                         acc_q[rsnp_pkg::BB_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      acc_q <= p_sub_q ? acc_base - acc_sh : acc_base + acc_sh;
      if (p_step_q == rsnp_pkg::MAC_XX0) begin
        bb_q     <= acc_q[rsnp_pkg::BB_W-1:0];
        bb_mag_q <= bb_abs[rsnp_pkg::OPA_W-1:0];
      end
      if (p_step_q == rsnp_pkg::MAC_BB0) begin
        sum_q <= acc_q[rsnp_pkg::SUM_W-1:0];
      end
    end
  end

  // disc = b^2 - (|oc|^2 - r^2) * 2^(2F), both signs of the bracket in one subtract
  assign disc_full = $signed({2'b00, acc_q}) -
                     ($signed(rsnp_pkg::DISC_W'(diff_q)) <<< (2 * rsnp_pkg::FRAC_BITS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_en) begin
      diff_q <= $signed({1'b0, sum_q}) -
                $signed(rsnp_pkg::DIFF_W'({radius_sq_i, {rsnp_pkg::FRAC_BITS{1'b0}}}));
    end
    if (cmd_i.disc_en) begin
      disc_neg_q <= disc_full[rsnp_pkg::DISC_W-1];
    end
    if (cmd_i.t_en) begin
      t_q <= -rsnp_pkg::T_W'(bb_q) - rsnp_pkg::T_W'(root);
    end
  end

  rsnp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .init_i  (cmd_i.disc_en),
    .step_i  (cmd_i.sqrt_step),
    .value_i (disc_full[rsnp_pkg::ACC_W-1:0]),
    .root_o  (root)
  );

  assign status_o.disc_neg = disc_neg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en && !disc_neg_q && (t_q > 0) && (!found_q || (t_q < best_t_q))) begin
      best_t_q    <= t_q;
      best_slot_q <= cmd_i.idx;
    end
  end

  assign dist_full = best_t_q[rsnp_pkg::T_W-1:rsnp_pkg::FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      sel_vld_q   <= 1'b0;
      sel_slot_q  <= '0;
      res_vld_o   <= 1'b0;
      hit_found_o <= 1'b0;
      hit_slot_o  <= '0;
      hit_dist_o  <= '0;
      sel_chg_o   <= 1'b0;
    end else begin
      res_vld_o <= cmd_i.load_res | cmd_i.fin_en;
      if (cmd_i.pick_init) begin
        found_q <= 1'b0;
      end else if (cmd_i.cmp_en && !disc_neg_q && (t_q > 0) &&
                   (!found_q || (t_q < best_t_q))) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load_res) begin
        hit_found_o <= 1'b0;
        hit_slot_o  <= '0;
        hit_dist_o  <= '0;
        sel_chg_o   <= 1'b0;
      end else if (cmd_i.fin_en) begin
        hit_found_o <= found_q;
        hit_slot_o  <= found_q ? best_slot_q : '0;
        if (!found_q) begin
          hit_dist_o <= '0;
        end else if (|dist_full[$bits(dist_full)-1:rsnp_pkg::DIST_W]) begin
          hit_dist_o <= '1;
        end else begin
          hit_dist_o <= dist_full[rsnp_pkg::DIST_W-1:0];
        end
        sel_chg_o  <= (found_q != sel_vld_q) || (found_q && (best_slot_q != sel_slot_q));
        sel_vld_q  <= found_q;
        sel_slot_q <= found_q ? best_slot_q : '0;
      end
    end
  end

endmodule

// ===== design/ray_sphere_nearest_pick_core.sv =====
// Load item: busy stays low, result strobe (done_o) in the cycle after start.
// Pick item: each of the n slots taking part (n <= 64) goes through the 12-step shared MAC
// and the 54-step digit-serial square root before the next slot is read;
// a slot with a negative discriminant skips the root.
// One item at a time; the result strobe is one cycle wide and is never held off.
// Reset (rst_ni low, async) clears control, selection and config; the centre table is kept.
module ray_sphere_nearest_pick_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic [rsnp_pkg::SLOT_W-1:0]         slot_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   center_x_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   center_y_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   center_z_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   origin_x_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   origin_y_i,
  input  logic signed [rsnp_pkg::CRD_W-1:0]   origin_z_i,
  input  logic signed [rsnp_pkg::DIR_W-1:0]   dir_x_i,
  input  logic signed [rsnp_pkg::DIR_W-1:0]   dir_y_i,
  input  logic signed [rsnp_pkg::DIR_W-1:0]   dir_z_i,
  output logic                                done_o,
  output logic                                hit_found_o,
  output logic [rsnp_pkg::SLOT_W-1:0]         hit_slot_o,
  output logic [rsnp_pkg::DIST_W-1:0]         hit_distance_o,
  output logic                                selection_changed_o
);

  logic [rsnp_pkg::CNT_W-1:0] obj_count_q;
  logic [rsnp_pkg::RAD_W-1:0] radius_sq_q;
  logic                       cfg_wr;
  rsnp_pkg::cmd_t             cmd;
  rsnp_pkg::status_t          status;
  logic                       start_ok;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obj_count_q <= '0;
      radius_sq_q <= 32'd262144;
    end else if (cfg_wr) begin
      if (paddr[2] == rsnp_pkg::REG_OBJ_COUNT) begin
        obj_count_q <= pwdata[rsnp_pkg::CNT_W-1:0];
      end else begin
        radius_sq_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == rsnp_pkg::REG_RADIUS) ? radius_sq_q :
                  32'(obj_count_q);

  assign start_ok = start & ~busy;

  rsnp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_ok),
    .opcode_i    (opcode_i),
    .obj_count_i (obj_count_q),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  rsnp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .radius_sq_i (radius_sq_q),
    .slot_i      (slot_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .center_z_i  (center_z_i),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .origin_z_i  (origin_z_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .res_vld_o   (done_o),
    .hit_found_o (hit_found_o),
    .hit_slot_o  (hit_slot_o),
    .hit_dist_o  (hit_distance_o),
    .sel_chg_o   (selection_changed_o)
  );

endmodule

// ===== design/rsnp_checker.sv =====
module rsnp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                opcode_i,
  input logic                                done_o,
  input logic                                hit_found_o,
  input logic [rsnp_pkg::SLOT_W-1:0]         hit_slot_o,
  input logic [rsnp_pkg::DIST_W-1:0]         hit_distance_o,
  input logic                                selection_changed_o
);

  // a load answers next cycle with an all-zero item
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == rsnp_pkg::OP_LOAD) |=>
      (done_o && !hit_found_o && hit_slot_o == '0 && hit_distance_o == '0 &&
       !selection_changed_o))
    else $error("load item result wrong");

  a_pick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == rsnp_pkg::OP_PICK) |=> (busy && !done_o))
    else $error("pick item did not go busy");

  a_pick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("pick finished without result");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_found_o) |-> (hit_slot_o == '0 && hit_distance_o == '0))
    else $error("miss carries slot or distance");

endmodule

bind ray_sphere_nearest_pick_core rsnp_checker u_rsnp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .start               (start),
  .busy                (busy),
  .opcode_i            (opcode_i),
  .done_o              (done_o),
  .hit_found_o         (hit_found_o),
  .hit_slot_o          (hit_slot_o),
  .hit_distance_o      (hit_distance_o),
  .selection_changed_o (selection_changed_o)
);

// ===== tb/ray_sphere_nearest_pick_core_tb.sv =====
module ray_sphere_nearest_pick_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int          UNIT        = 65536;

  typedef struct {
    logic                              op;
    logic [rsnp_pkg::SLOT_W-1:0]       slot;
    logic signed [rsnp_pkg::CRD_W-1:0] cx, cy, cz;
    logic signed [rsnp_pkg::CRD_W-1:0] ox, oy, oz;
    logic signed [rsnp_pkg::DIR_W-1:0] dx, dy, dz;
  } pick_item_t;

  typedef struct {
    logic                        found;
    logic [rsnp_pkg::SLOT_W-1:0] slot;
    logic [rsnp_pkg::DIST_W-1:0] distance;
    logic                        changed;
  } hit_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = rsnp_pkg::OP_LOAD;
  logic [rsnp_pkg::SLOT_W-1:0] slot_i = '0;
  logic signed [rsnp_pkg::CRD_W-1:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic signed [rsnp_pkg::CRD_W-1:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [rsnp_pkg::DIR_W-1:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic done_o, hit_found_o, selection_changed_o;
  logic [rsnp_pkg::SLOT_W-1:0] hit_slot_o;
  logic [rsnp_pkg::DIST_W-1:0] hit_distance_o;

  ray_sphere_nearest_pick_core u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow state
  logic signed [rsnp_pkg::CRD_W-1:0] ctr_x [rsnp_pkg::OBJ_MAX];
  logic signed [rsnp_pkg::CRD_W-1:0] ctr_y [rsnp_pkg::OBJ_MAX];
  logic signed [rsnp_pkg::CRD_W-1:0] ctr_z [rsnp_pkg::OBJ_MAX];
  logic                        sel_valid = 1'b0;
  logic [rsnp_pkg::SLOT_W-1:0] sel_slot = '0;
  logic [rsnp_pkg::CNT_W-1:0]  obj_count = '0;
  logic [rsnp_pkg::RAD_W-1:0]  radius_sq = 32'd262144;

  hit_res_t pending_hits[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_cnt = 0;

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0] s, cand;
    s = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = s | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= v) s = cand;
    end
    return s;
  endfunction

  function automatic logic [127:0] sq_mag(longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return {64'd0, m} * {64'd0, m};
  endfunction

  // load: stores the centre, all-zero result; pick: nearest hit over the active slots, updates the stored selection
  function automatic hit_res_t nearest_hit(pick_item_t it);
    hit_res_t r;
    int unsigned n;
    longint ox, oy, oz, bb, t, best_t;
    logic [127:0] bsq, sum, rr, disc, cpos;
    logic [63:0] d;
    r = '{default: '0};
    if (it.op == rsnp_pkg::OP_LOAD) begin
      ctr_x[it.slot] = it.cx;
      ctr_y[it.slot] = it.cy;
      ctr_z[it.slot] = it.cz;
      return r;
    end
    n = (obj_count > rsnp_pkg::OBJ_MAX) ? rsnp_pkg::OBJ_MAX : obj_count;
    rr = {80'd0, radius_sq, 16'd0};
    best_t = 0;
    for (int i = 0; i < n; i++) begin
      ox = longint'(it.ox) - longint'(ctr_x[i]);
      oy = longint'(it.oy) - longint'(ctr_y[i]);
      oz = longint'(it.oz) - longint'(ctr_z[i]);
      bb = ox * longint'(it.dx) + oy * longint'(it.dy) + oz * longint'(it.dz);
      bsq = sq_mag(bb);
      sum = sq_mag(ox) + sq_mag(oy) + sq_mag(oz);
      if (sum >= rr) begin
        cpos = (sum - rr) << (2 * rsnp_pkg::FRAC_BITS);
        if (bsq < cpos) continue;
        disc = bsq - cpos;
      end else begin
        disc = bsq + ((rr - sum) << (2 * rsnp_pkg::FRAC_BITS));
      end
      t = -bb - longint'(floor_sqrt(disc));
      if (t > 0 && (!r.found || t < best_t)) begin
        r.found = 1'b1;
        best_t = t;
        r.slot = i[rsnp_pkg::SLOT_W-1:0];
      end
    end
    r.changed = (r.found != sel_valid) || (r.found && r.slot != sel_slot);
    sel_valid = r.found;
    sel_slot = r.found ? r.slot : '0;
    if (r.found) begin
      d = 64'(best_t) >> rsnp_pkg::FRAC_BITS;
      r.distance = (d > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : d[rsnp_pkg::DIST_W-1:0];
    end
    return r;
  endfunction

  task automatic send_item(pick_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= it.op;
    slot_i <= it.slot;
    center_x_i <= it.cx; center_y_i <= it.cy; center_z_i <= it.cz;
    origin_x_i <= it.ox; origin_y_i <= it.oy; origin_z_i <= it.oz;
    dir_x_i <= it.dx; dir_y_i <= it.dy; dir_z_i <= it.dz;
    do @(posedge clk_i); while (busy);
    pending_hits.insert(pending_hits.size(), nearest_hit(it));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic reg_sel, logic [31:0] val);
    paddr <= {reg_sel, 2'b00};
    pwdata <= val;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == rsnp_pkg::REG_OBJ_COUNT) obj_count = val[rsnp_pkg::CNT_W-1:0];
    else radius_sq = val;
  endtask

  task automatic set_regs(logic [31:0] cnt, logic [31:0] rsq);
    wait_idle();
    apb_write(rsnp_pkg::REG_OBJ_COUNT, cnt);
    apb_write(rsnp_pkg::REG_RADIUS, rsq);
  endtask

  function automatic pick_item_t load_of(int s, int x, int y, int z);
    pick_item_t it;
    it = '{default: '0};
    it.op = rsnp_pkg::OP_LOAD;
    it.slot = s[rsnp_pkg::SLOT_W-1:0];
    it.cx = x; it.cy = y; it.cz = z;
    return it;
  endfunction

  function automatic pick_item_t ray_of(int x, int y, int z, int a, int b, int c);
    pick_item_t it;
    it = '{default: '0};
    it.op = rsnp_pkg::OP_PICK;
    it.ox = x; it.oy = y; it.oz = z;
    it.dx = a[rsnp_pkg::DIR_W-1:0];
    it.dy = b[rsnp_pkg::DIR_W-1:0];
    it.dz = c[rsnp_pkg::DIR_W-1:0];
    return it;
  endfunction

  function automatic int rnd_coord();
    return int'($urandom_range(0, 60 * UNIT)) - 30 * UNIT;
  endfunction

  // unit ray from origin towards (tx,ty,tz) with some jitter
  function automatic pick_item_t aimed_ray(int tx, int ty, int tz);
    int x, y, z;
    real vx, vy, vz, len;
    x = rnd_coord(); y = rnd_coord(); z = rnd_coord();
    vx = real'(tx) - real'(x) + (real'($urandom_range(0, 2 * UNIT)) - UNIT);
    vy = real'(ty) - real'(y) + (real'($urandom_range(0, 2 * UNIT)) - UNIT);
    vz = real'(tz) - real'(z) + (real'($urandom_range(0, 2 * UNIT)) - UNIT);
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 1.0) return ray_of(x, y, z, 0, 0, UNIT);
    return ray_of(x, y, z, $rtoi(vx / len * UNIT), $rtoi(vy / len * UNIT),
                  $rtoi(vz / len * UNIT));
  endfunction

  function automatic pick_item_t noise_item();
    pick_item_t it;
    it.op = 1'($urandom_range(1));
    it.slot = rsnp_pkg::SLOT_W'($urandom());
    it.cx = $urandom(); it.cy = $urandom(); it.cz = $urandom();
    it.ox = $urandom(); it.oy = $urandom(); it.oz = $urandom();
    it.dx = rsnp_pkg::DIR_W'($urandom());
    it.dy = rsnp_pkg::DIR_W'($urandom());
    it.dz = rsnp_pkg::DIR_W'($urandom());
    return it;
  endfunction

  always @(posedge clk_i) begin
    hit_res_t e;
    if (done_o) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result at %0t", $realtime);
      end else begin
        e = pending_hits.pop_front();
        if (hit_found_o !== e.found || hit_slot_o !== e.slot ||
            hit_distance_o !== e.distance || selection_changed_o !== e.changed) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch at %0t: exp found=%0b slot=%0d distance=%0d chg=%0b, ",
                      "got %0b %0d %0d %0b"},
                     $realtime, e.found, e.slot, e.distance, e.changed, hit_found_o,
                     hit_slot_o, hit_distance_o, selection_changed_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || !rst_ni) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("ray_sphere_nearest_pick_core verification failed");
      $finish;
    end
  end

  task automatic test_empty_and_fill();
    send_item(ray_of(0, 0, 0, 0, 0, UNIT));
    for (int s = 0; s < rsnp_pkg::OBJ_MAX; s++)
      send_item(load_of(s, rnd_coord(), rnd_coord(), rnd_coord()));
  endtask

  task automatic test_directed();
    set_regs(2, 32'd262144);
    send_item(load_of(0, 0, 0, 10 * UNIT));
    send_item(load_of(1, 0, 0, 5 * UNIT));
    send_item(ray_of(0, 0, 0, 0, 0, UNIT));           // nearer of two
    send_item(ray_of(0, 0, 0, 0, 0, -UNIT));          // facing away: miss
    send_item(ray_of(0, 0, 5 * UNIT, 0, 0, UNIT));    // origin inside sphere
    send_item(load_of(1, 0, 0, 10 * UNIT));
    send_item(ray_of(0, 0, 0, 0, 0, UNIT));           // tie, lower slot wins
    set_regs(2, 32'd0);
    send_item(ray_of(0, 0, 0, 0, 0, UNIT));           // zero radius
    set_regs(1, 32'hFFFF_FFFF);
    send_item(load_of(0, 32'h7FFF_FFFF, 0, 0));
    send_item(ray_of(32'h8000_0000, 0, 0, UNIT, 0, 0));   // far hit, saturated
    send_item(ray_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     -131072, 131071, -131072));
    send_item(load_of(63, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    set_regs(127, 32'd262144);
    send_item(aimed_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(ray_of(0, 0, 0, 0, 0, 0));              // zero direction
    set_regs(64, 32'd1 << 20);
    send_item(load_of(0, 0, 0, 3 * UNIT));
    send_item(ray_of(0, 0, 0, 0, 0, UNIT));
  endtask

  task automatic test_random_phase(int unsigned pct, int unsigned items);
    int unsigned r, tgt;
    idle_pct = pct;
    for (int k = 0; k < items; k++) begin
      if (k % 15 == 0) begin
        r = $urandom_range(32768, 524288);
        set_regs($urandom_range(1, 8),
                 ($urandom_range(9) == 0) ? $urandom() : 32'((64'(r) * r) >> 16));
      end
      r = $urandom_range(99);
      if (r < 25) begin
        send_item(load_of($urandom_range(rsnp_pkg::OBJ_MAX - 1), rnd_coord(),
                          rnd_coord(), rnd_coord()));
      end else if (r < 85) begin
        tgt = $urandom_range(obj_count - 1);
        send_item(aimed_ray(ctr_x[tgt], ctr_y[tgt], ctr_z[tgt]));
      end else begin
        send_item(noise_item());
      end
    end
  endtask

  task automatic test_full_table();
    int unsigned tgt;
    set_regs(64, 32'd1 << 18);
    for (int k = 0; k < 3; k++) begin
      tgt = $urandom_range(rsnp_pkg::OBJ_MAX - 1);
      send_item(aimed_ray(ctr_x[tgt], ctr_y[tgt], ctr_z[tgt]));
    end
    set_regs(127, 32'd1 << 20);
    send_item(aimed_ray(ctr_x[5], ctr_y[5], ctr_z[5]));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_fill();
    test_directed();
    test_random_phase(13, 18);
    test_random_phase(52, 18);
    test_random_phase(0, 18);
    test_full_table();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("ray_sphere_nearest_pick_core verification clean");
    else $display("ray_sphere_nearest_pick_core verification failed");
    $finish;
  end

endmodule

// ===== ray_sphere_nearest_pick_core.f =====
design/rsnp_pkg.sv
design/rsnp_sqrt.sv
design/rsnp_ctrl.sv
design/rsnp_dp.sv
design/ray_sphere_nearest_pick_core.sv
design/rsnp_checker.sv
tb/ray_sphere_nearest_pick_core_tb.sv
